### rtl/nts_pkg.sv
// Shared types and constants for the nearest-timestamp sample buffer.
package nts_pkg;

  // Field widths
  localparam int TIME_W = 48;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 7;
  localparam int BEST_W = 32;

  // Default store depth
  localparam int DEPTH_DEFAULT = 64;

  // Match window (3000 s) and end-of-stream lag (4 s), in microseconds
  localparam logic [BEST_W-1:0] WINDOW_US  = 32'd3000000000;
  localparam logic [TIME_W-1:0] END_LAG_US = 48'd4000000;

  // Reset value of the max_entries register
  localparam logic [CFG_W-1:0] MAX_RESET = 7'd50;

  // Operation codes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_EMIT
  } state_t;

  // Control from the sequencer to the match unit
  typedef struct packed {
    logic start;  // clear the running best at query accept
    logic valid;  // time read data is valid this cycle
    logic first;  // entry under compare is the oldest
    logic last;   // entry under compare is the newest
  } match_ctl_t;

endpackage

### rtl/nts_ram.sv
// Generic simple dual-port RAM with registered read.
module nts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/nts_ptr.sv
// Ring pointer and occupancy tracking for the sample store.
module nts_ptr #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [$clog2(DEPTH+1)-1:0] limit,
  output logic [$clog2(DEPTH)-1:0]   oldest,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic [$clog2(DEPTH)-1:0]   wr_slot
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic          full;
  logic [AW-1:0] oldest_a;
  logic [CW-1:0] count_a;
  logic [CW-1:0] count_b;
  logic [CW-1:0] drop;
  logic [SW-1:0] wr_sum;
  logic [SW-1:0] old_sum;
  logic [AW-1:0] oldest_next;
  logic [CW-1:0] count_next;

  // A full store loses its oldest entry before the new one goes in
  always_comb begin
    full     = (count == CW'(DEPTH));
    oldest_a = oldest;
    count_a  = count;
    if (full) begin
      oldest_a = (oldest == AW'(DEPTH - 1)) ? '0 : oldest + 1'b1;
      count_a  = count - 1'b1;
    end
  end

  // Write slot: (oldest + count) mod DEPTH, the sum stays below 2*DEPTH
  always_comb begin
    wr_sum  = SW'(oldest_a) + SW'(count_a);
    wr_slot = (wr_sum >= SW'(DEPTH)) ? AW'(wr_sum - SW'(DEPTH)) : AW'(wr_sum);
  end

  // Trim down to the limit after the append
  always_comb begin
    count_b     = count_a + 1'b1;
    drop        = (count_b > limit) ? count_b - limit : '0;
    old_sum     = SW'(oldest_a) + SW'(drop);
    oldest_next = (old_sum >= SW'(DEPTH)) ? AW'(old_sum - SW'(DEPTH)) : AW'(old_sum);
    count_next  = count_b - drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      count  <= '0;
    end else if (push) begin
      oldest <= oldest_next;
      count  <= count_next;
    end
  end

endmodule

### rtl/nts_match.sv
// Running nearest-timestamp compare over the scanned entries.
module nts_match
  import nts_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  match_ctl_t               ctl,
  input  logic [TIME_W-1:0]        query_time,
  input  logic [$clog2(DEPTH)-1:0] slot,
  input  logic [TIME_W-1:0]        rtime,
  output logic                     found,
  output logic [$clog2(DEPTH)-1:0] best_slot,
  output logic [TIME_W-1:0]        best_time,
  output logic [TIME_W-1:0]        oldest_time,
  output logic [TIME_W-1:0]        newest_time
);

  logic [BEST_W-1:0] best;
  logic [TIME_W-1:0] delta;
  logic              closer;

  // Absolute distance, strictly closer than the best so far (oldest wins ties)
  always_comb begin
    delta  = (rtime >= query_time) ? rtime - query_time : query_time - rtime;
    closer = (delta[TIME_W-1:BEST_W] == '0) && (delta[BEST_W-1:0] < best);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.start) begin
      found <= 1'b0;
    end else if (ctl.valid && closer) begin
      found <= 1'b1;
    end
  end

  // Best candidate and end-point timestamps
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      best <= WINDOW_US;
    end else if (ctl.valid) begin
      if (closer) begin
        best      <= delta[BEST_W-1:0];
        best_slot <= slot;
        best_time <= rtime;
      end
      if (ctl.first) begin
        oldest_time <= rtime;
      end
      if (ctl.last) begin
        newest_time <= rtime;
      end
    end
  end

endmodule

### rtl/nearest_timestamp_sample_buffer.sv
// Top level of the nearest-timestamp sample buffer.
//
// Input channel (in_valid / in_stall): operation 0 pushes a timestamped
// force/torque sample, operation 1 asks for the stored sample nearest to
// timestamp. A push does not stall the input and produces no transaction
// on the output. A query walks the stored entries oldest to newest, one
// time-memory read per cycle, then reads the matched sample from the data
// memory; it stalls the input until the result is loaded into the output
// register, and an empty store skips the scan and the data read.
// The scan length is set by the single read port of the time memory.
// Output channel (out_valid / out_stall): one transaction per query, held in
// an output register. While the receiver stalls, the block keeps taking
// pushes and can finish the next query; that one waits until the register
// frees. Configuration (cfg_valid / cfg_ready) writes max_entries, and is
// always ready. Reset empties the store and sets max_entries to 50; the
// memories are not cleared, stale entries are never read.
module nearest_timestamp_sample_buffer
  import nts_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_W-1:0]         cfg_data,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     operation,
  input  logic [TIME_W-1:0]        timestamp,
  input  logic signed [DATA_W-1:0] force_x,
  input  logic signed [DATA_W-1:0] force_y,
  input  logic signed [DATA_W-1:0] force_z,
  input  logic signed [DATA_W-1:0] torque_x,
  input  logic signed [DATA_W-1:0] torque_y,
  input  logic signed [DATA_W-1:0] torque_z,
  // output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     found,
  output logic [TIME_W-1:0]        matched_time,
  output logic signed [DATA_W-1:0] out_force_x,
  output logic signed [DATA_W-1:0] out_force_y,
  output logic signed [DATA_W-1:0] out_force_z,
  output logic signed [DATA_W-1:0] out_torque_x,
  output logic signed [DATA_W-1:0] out_torque_y,
  output logic signed [DATA_W-1:0] out_torque_z,
  output logic                     asked_too_late,
  output logic                     asked_too_early,
  output logic                     stream_ended
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int LW  = (CW > CFG_W) ? CW : CFG_W;
  localparam int SMP_W = 6 * DATA_W;

  state_t state, state_next;

  logic [CFG_W-1:0]  max_entries;
  logic [CW-1:0]     limit;

  logic              accept;
  logic              push;
  logic              query_acc;
  logic              issue;
  logic              emit_go;
  logic              data_rd_en;

  logic [AW-1:0]     oldest;
  logic [CW-1:0]     count;
  logic [AW-1:0]     wr_slot;

  logic [TIME_W-1:0] q_time;
  logic [CW-1:0]     issue_k;
  logic [AW-1:0]     issue_slot;
  logic              cmp_v;
  logic              cmp_first;
  logic              cmp_last;
  logic [AW-1:0]     cmp_slot;

  logic [TIME_W-1:0] time_rdata;
  logic [SMP_W-1:0]  smp_rdata;
  logic [SMP_W-1:0]  smp_wdata;

  match_ctl_t        mctl;
  logic              m_found;
  logic [AW-1:0]     best_slot;
  logic [TIME_W-1:0] best_time;
  logic [TIME_W-1:0] oldest_time;
  logic [TIME_W-1:0] newest_time;

  logic              late;
  logic              early;
  logic              ended;
  logic [TIME_W-1:0] lag;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_entries <= cfg_data;
    end
  end

  // Effective limit, clamped to the store depth
  assign limit = (LW'(max_entries) > LW'(DEPTH)) ? CW'(DEPTH) : CW'(max_entries);

  // Input handshake
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign push      = accept && (operation == OP_PUSH);
  assign query_acc = accept && (operation == OP_QUERY);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (query_acc) begin
          state_next = (count == '0) ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((issue_k == count) && !cmp_v) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    issue      = (state == ST_SCAN) && (issue_k != count);
    data_rd_en = (state == ST_FETCH);
    emit_go    = (state == ST_EMIT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Ring pointers
  nts_ptr #(
    .DEPTH (DEPTH)
  ) u_ptr (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .limit   (limit),
    .oldest  (oldest),
    .count   (count),
    .wr_slot (wr_slot)
  );

  // Sample memories
  assign smp_wdata = {torque_z, torque_y, torque_x, force_z, force_y, force_x};

  nts_ram #(
    .WIDTH (TIME_W),
    .DEPTH (DEPTH)
  ) u_time_ram (
    .clk   (clk),
    .we    (push),
    .waddr (wr_slot),
    .wdata (timestamp),
    .re    (issue),
    .raddr (issue_slot),
    .rdata (time_rdata)
  );

  nts_ram #(
    .WIDTH (SMP_W),
    .DEPTH (DEPTH)
  ) u_smp_ram (
    .clk   (clk),
    .we    (push),
    .waddr (wr_slot),
    .wdata (smp_wdata),
    .re    (data_rd_en),
    .raddr (best_slot),
    .rdata (smp_rdata)
  );

  // Scan address generation
  always_ff @(posedge clk) begin
    if (query_acc) begin
      q_time     <= timestamp;
      issue_k    <= '0;
      issue_slot <= oldest;
    end else if (issue) begin
      issue_k    <= issue_k + 1'b1;
      issue_slot <= (issue_slot == AW'(DEPTH - 1)) ? '0 : issue_slot + 1'b1;
    end
  end

  // Read-latency alignment for the compare
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_v <= 1'b0;
    end else begin
      cmp_v <= issue;
    end
  end

  always_ff @(posedge clk) begin
    cmp_first <= (issue_k == '0);
    cmp_last  <= (issue_k == count - 1'b1);
    cmp_slot  <= issue_slot;
  end

  // Match unit
  always_comb begin
    mctl.start = query_acc;
    mctl.valid = cmp_v;
    mctl.first = cmp_first;
    mctl.last  = cmp_last;
  end

  nts_match #(
    .DEPTH (DEPTH)
  ) u_match (
    .clk         (clk),
    .rst         (rst),
    .ctl         (mctl),
    .query_time  (q_time),
    .slot        (cmp_slot),
    .rtime       (time_rdata),
    .found       (m_found),
    .best_slot   (best_slot),
    .best_time   (best_time),
    .oldest_time (oldest_time),
    .newest_time (newest_time)
  );

  // Range flags, cleared for an empty store
  assign lag = q_time - newest_time;

  always_ff @(posedge clk) begin
    if (query_acc) begin
      late  <= 1'b0;
      early <= 1'b0;
      ended <= 1'b0;
    end else if (state == ST_FETCH) begin
      late  <= (newest_time < q_time);
      early <= (oldest_time > q_time);
      ended <= (newest_time < q_time) && (lag > END_LAG_US);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      found           <= m_found;
      matched_time    <= m_found ? best_time : '0;
      out_force_x     <= m_found ? smp_rdata[0*DATA_W +: DATA_W] : '0;
      out_force_y     <= m_found ? smp_rdata[1*DATA_W +: DATA_W] : '0;
      out_force_z     <= m_found ? smp_rdata[2*DATA_W +: DATA_W] : '0;
      out_torque_x    <= m_found ? smp_rdata[3*DATA_W +: DATA_W] : '0;
      out_torque_y    <= m_found ? smp_rdata[4*DATA_W +: DATA_W] : '0;
      out_torque_z    <= m_found ? smp_rdata[5*DATA_W +: DATA_W] : '0;
      asked_too_late  <= late;
      asked_too_early <= early;
      stream_ended    <= ended;
    end
  end

endmodule
